[design/ursim_pkg.sv]
`timescale 1ns / 1ps
package ursim_pkg;

    localparam int NUM_USERS_DEF = 64;
    localparam int NUM_ITEMS_DEF = 1024;

    localparam int USER_W   = 6;
    localparam int ITEM_W   = 10;
    localparam int RATING_W = 4;
    localparam int SIM_W    = 16;
    localparam int MEAN_W   = 11;

    localparam logic [RATING_W-1:0] RATING_MAX = 4'd10;
    localparam logic [14:0]         SIM_ONE    = 15'd16384;
    localparam logic                ACT_WRITE  = 1'b0;
    localparam logic                ACT_QUERY  = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_P1,
        S_P1_WAIT,
        S_P2,
        S_P2_WAIT,
        S_CHECK,
        S_DEN,
        S_DEN_WAIT,
        S_SQ,
        S_SQ_WAIT,
        S_MID,
        S_ODD,
        S_MUL,
        S_MUL_WAIT,
        S_CMP,
        S_DIV,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        M_DEN,
        M_SQ,
        M_LHS
    } t_msel;

    typedef struct packed {
        logic  clr;
        logic  wr;
        logic  load;
        logic  scan;
        logic  p2_begin;
        logic  mul_go;
        t_msel msel;
        logic  cap_den;
        logic  cap_rhs;
        logic  sim_zero;
        logic  mid;
        logic  sq_odd;
        logic  cmp;
        logic  sim_fin;
        logic  div_go;
        logic  out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic k_last;
        logic pipe_idle;
        logic q_zero;
        logic mul_done;
        logic srch_done;
        logic div_done;
    } t_sts;

endpackage

[design/user_rating_similarity.sv]
`timescale 1ns / 1ps
// Write words leave busy low. A query word keeps busy high while the sequence runs, and
// o_valid strobes in the cycle after the last busy cycle. The two item passes, the
// shift-add multiplier, the search and the mean divider set how long busy stays high.
// One word at a time; the result strobe o_valid lasts one cycle, no stall.
// Synchronous active-low reset, then a sweep clears all NUM_USERS*NUM_ITEMS store
// entries (65536 at defaults) with busy high before the first word is taken.
module user_rating_similarity #(
    parameter int NUM_USERS = ursim_pkg::NUM_USERS_DEF,
    parameter int NUM_ITEMS = ursim_pkg::NUM_ITEMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_action,
    input  logic [ursim_pkg::USER_W-1:0]       i_user,
    input  logic [ursim_pkg::ITEM_W-1:0]       i_item,
    input  logic [ursim_pkg::RATING_W-1:0]     i_rating_halves,
    input  logic [ursim_pkg::USER_W-1:0]       i_other_user,
    output logic                               o_valid,
    output logic signed [ursim_pkg::SIM_W-1:0] o_similarity,
    output logic [ursim_pkg::MEAN_W-1:0]       o_mean_first
);
    import ursim_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer: clear sweep, two scan passes, multiply, search and divide steps.
    ursim_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Datapath: rating store, accumulators, shared multiplier, mean divider.
    ursim_dp #(
        .NUM_USERS (NUM_USERS),
        .NUM_ITEMS (NUM_ITEMS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_user          (i_user),
        .i_item          (i_item),
        .i_rating_halves (i_rating_halves),
        .i_other_user    (i_other_user),
        .o_valid         (o_valid),
        .o_similarity    (o_similarity),
        .o_mean_first    (o_mean_first)
    );

`ifndef SYNTHESIS
    // A result appears only once the sequencer has returned to idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    // A write word never makes the block busy.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_WRITE) |=> !busy)
        else $error("write left block busy");

    // A query word starts a busy period.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_QUERY) |=> busy)
        else $error("query not started");

    // Similarity stays within plus and minus one.
    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_similarity <= 16'sd16384 && o_similarity >= -16'sd16384))
        else $error("similarity out of range");
`endif

endmodule

[design/ursim_ctrl.sv]
`timescale 1ns / 1ps
module ursim_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_action,
    input  ursim_pkg::t_sts i_sts,
    output ursim_pkg::t_cmd o_cmd,
    output logic            o_busy
);
    import ursim_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_P1;
                    end
                end
            end
            S_P1: begin
                o_cmd.scan = 1'b1;
                if (i_sts.k_last) n_state = S_P1_WAIT;
            end
            S_P1_WAIT: begin
                if (i_sts.pipe_idle) begin
                    o_cmd.p2_begin = 1'b1;
                    n_state        = S_P2;
                end
            end
            S_P2: begin
                o_cmd.scan = 1'b1;
                if (i_sts.k_last) n_state = S_P2_WAIT;
            end
            S_P2_WAIT: begin
                if (i_sts.pipe_idle) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.q_zero) begin
                    o_cmd.sim_zero = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.msel   = M_DEN;
                n_state      = S_DEN_WAIT;
            end
            S_DEN_WAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.cap_den = 1'b1;
                    n_state       = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.msel   = M_SQ;
                n_state      = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.cap_rhs = 1'b1;
                    n_state       = S_MID;
                end
            end
            S_MID: begin
                if (i_sts.srch_done) begin
                    o_cmd.sim_fin = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    o_cmd.mid = 1'b1;
                    n_state   = S_ODD;
                end
            end
            S_ODD: begin
                o_cmd.sq_odd = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.msel   = M_LHS;
                n_state      = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (i_sts.mul_done) n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_MID;
            end
            S_DIV: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.out = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/ursim_dp.sv]
`timescale 1ns / 1ps
module ursim_dp #(
    parameter int NUM_USERS = ursim_pkg::NUM_USERS_DEF,
    parameter int NUM_ITEMS = ursim_pkg::NUM_ITEMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ursim_pkg::t_cmd                    i_cmd,
    output ursim_pkg::t_sts                    o_sts,
    input  logic [ursim_pkg::USER_W-1:0]       i_user,
    input  logic [ursim_pkg::ITEM_W-1:0]       i_item,
    input  logic [ursim_pkg::RATING_W-1:0]     i_rating_halves,
    input  logic [ursim_pkg::USER_W-1:0]       i_other_user,
    output logic                               o_valid,
    output logic signed [ursim_pkg::SIM_W-1:0] o_similarity,
    output logic [ursim_pkg::MEAN_W-1:0]       o_mean_first
);
    import ursim_pkg::*;

    localparam int DEPTH = NUM_USERS * NUM_ITEMS;
    localparam int MAW   = $clog2(DEPTH);
    localparam int KW    = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    localparam int IW    = $clog2(NUM_ITEMS + 1);
    localparam int SW    = $clog2(10 * NUM_ITEMS + 1);
    localparam int CW    = SW + 1;
    localparam int PW    = 2 * CW;
    localparam int AW    = PW + IW;
    localparam int MBW   = (AW > 30) ? AW : 30;
    localparam int BW    = 2 * AW + 30;
    localparam int MCW   = $clog2(MBW + 1);
    localparam int DW    = SW + IW + 12;

    // rating store
    logic [RATING_W-1:0] r_mem [DEPTH];
    logic [MAW-1:0]      r_clr_addr;
    logic [RATING_W-1:0] r_rd_u, r_rd_v;

    logic [31:0]         wr_full, rdu_full, rdv_full;
    logic                wr_ok, we;
    logic [MAW-1:0]      wa;
    logic [RATING_W-1:0] wd, sat;

    // query registers
    logic [USER_W-1:0]   r_u, r_v;
    logic                r_uok, r_vok, r_pass2;
    logic [KW-1:0]       r_k;
    logic                r_v0, r_v1, r_v2;
    logic [SW-1:0]       r_su, r_sv;
    logic [IW-1:0]       r_nu, r_nv;
    logic signed [CW-1:0] r_cu, r_cv;
    logic                r_fa, r_fb;
    logic signed [PW-1:0] r_pn, r_pu, r_pv;
    logic signed [AW-1:0] r_num, r_qu, r_qv;

    logic [RATING_W-1:0] ra, rb;
    logic signed [CW-1:0] ca_c, cb_c;

    // shared shift-add multiplier
    logic [BW-1:0]  r_ma, r_macc, r_den, r_rhs;
    logic [MBW-1:0] r_mb;
    logic [MCW-1:0] r_mcnt;
    logic [AW-1:0]  mag;
    logic [BW-1:0]  op_a;
    logic [MBW-1:0] op_b;

    // search and result
    logic [14:0] r_lo, r_hi, r_mid, r_odd;
    logic [29:0] r_odd2;
    logic [15:0] mid_sum;
    logic [14:0] mid_c;
    logic        r_neg;
    logic signed [SIM_W-1:0] r_sim;

    // mean divider
    logic [DW-1:0]     r_rem, r_dsh;
    logic [MEAN_W-1:0] r_q;
    logic [3:0]        r_dcnt;
    logic              r_vld;
    logic [MEAN_W-1:0] r_mean;

    assign sat      = (i_rating_halves > RATING_MAX) ? RATING_MAX : i_rating_halves;
    assign wr_full  = 32'(i_user) * 32'(NUM_ITEMS) + 32'(i_item);
    assign wr_ok    = (32'(i_user) < 32'(NUM_USERS)) && (32'(i_item) < 32'(NUM_ITEMS));
    assign we       = i_cmd.clr | (i_cmd.wr & wr_ok);
    assign wa       = i_cmd.clr ? r_clr_addr : wr_full[MAW-1:0];
    assign wd       = i_cmd.clr ? '0 : sat;
    assign rdu_full = 32'(r_u) * 32'(NUM_ITEMS) + 32'(r_k);
    assign rdv_full = 32'(r_v) * 32'(NUM_ITEMS) + 32'(r_k);

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd_u <= r_mem[rdu_full[MAW-1:0]];
        r_rd_v <= r_mem[rdv_full[MAW-1:0]];
    end

    assign ra   = r_uok ? r_rd_u : '0;
    assign rb   = r_vok ? r_rd_v : '0;
    assign ca_c = $signed(CW'($signed({1'b0, r_nu}) * $signed({1'b0, ra})))
                  - $signed({1'b0, r_su});
    assign cb_c = $signed(CW'($signed({1'b0, r_nv}) * $signed({1'b0, rb})))
                  - $signed({1'b0, r_sv});

    assign mag = r_num[AW-1] ? AW'(-r_num) : AW'(r_num);

    always_comb begin
        case (i_cmd.msel)
            M_DEN: begin
                op_a = BW'(unsigned'(r_qu));
                op_b = MBW'(unsigned'(r_qv));
            end
            M_SQ: begin
                op_a = BW'(mag);
                op_b = MBW'(mag);
            end
            M_LHS: begin
                op_a = r_den;
                op_b = MBW'(r_odd2);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mid_sum = 16'(r_lo) + 16'(r_hi) + 16'd1;
    assign mid_c   = mid_sum[15:1];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_mcnt     <= '0;
            r_dcnt     <= '0;
            r_vld      <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + 1'b1;
            r_v0  <= i_cmd.scan;
            r_v1  <= r_v0 & r_pass2;
            r_v2  <= r_v1;
            r_vld <= i_cmd.out;
            if (i_cmd.mul_go) begin
                r_mcnt <= MCW'(MBW);
            end else if (r_mcnt != '0) begin
                r_mcnt <= r_mcnt - 1'b1;
            end
            if (i_cmd.div_go) begin
                r_dcnt <= 4'(MEAN_W);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u     <= i_user;
            r_v     <= i_other_user;
            r_uok   <= 32'(i_user) < 32'(NUM_USERS);
            r_vok   <= 32'(i_other_user) < 32'(NUM_USERS);
            r_pass2 <= 1'b0;
            r_k     <= '0;
            r_su    <= '0;
            r_sv    <= '0;
            r_nu    <= '0;
            r_nv    <= '0;
            r_num   <= '0;
            r_qu    <= '0;
            r_qv    <= '0;
        end else begin
            if (i_cmd.p2_begin) begin
                r_pass2 <= 1'b1;
                r_k     <= '0;
            end else if (i_cmd.scan) begin
                r_k <= r_k + 1'b1;
            end
            // first pass: sums and counts
            if (r_v0 && !r_pass2) begin
                if (ra != '0) begin
                    r_su <= r_su + SW'(ra);
                    r_nu <= r_nu + 1'b1;
                end
                if (rb != '0) begin
                    r_sv <= r_sv + SW'(rb);
                    r_nv <= r_nv + 1'b1;
                end
            end
            // second pass: accumulate centered products
            if (r_v2) begin
                r_num <= r_num + AW'(r_pn);
                r_qu  <= r_qu + AW'(r_pu);
                r_qv  <= r_qv + AW'(r_pv);
            end
        end

        r_cu <= ca_c;
        r_cv <= cb_c;
        r_fa <= (ra != '0);
        r_fb <= (rb != '0);
        r_pn <= (r_fa && r_fb) ? PW'(r_cu * r_cv) : '0;
        r_pu <= r_fa ? PW'(r_cu * r_cu) : '0;
        r_pv <= r_fb ? PW'(r_cv * r_cv) : '0;

        if (i_cmd.mul_go) begin
            r_ma   <= op_a;
            r_mb   <= op_b;
            r_macc <= '0;
        end else if (r_mcnt != '0) begin
            if (r_mb[0]) r_macc <= r_macc + r_ma;
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end

        if (i_cmd.cap_den) r_den <= r_macc;
        if (i_cmd.cap_rhs) begin
            r_rhs <= r_macc << 30;
            r_lo  <= '0;
            r_hi  <= SIM_ONE;
            r_neg <= r_num[AW-1];
        end
        if (i_cmd.mid) begin
            r_mid <= mid_c;
            r_odd <= 15'({mid_c, 1'b0} - 16'd1);
        end
        if (i_cmd.sq_odd) r_odd2 <= {15'd0, r_odd} * {15'd0, r_odd};
        if (i_cmd.cmp) begin
            if (r_macc <= r_rhs) begin
                r_lo <= r_mid;
            end else begin
                r_hi <= r_mid - 1'b1;
            end
        end
        if (i_cmd.sim_zero) r_sim <= '0;
        if (i_cmd.sim_fin) r_sim <= r_neg ? -$signed(16'(r_lo)) : $signed(16'(r_lo));

        // restoring divide for the mean, one quotient bit a cycle
        if (i_cmd.div_go) begin
            r_rem <= (DW'(r_su) << 8) + DW'(r_nu);
            r_dsh <= DW'(r_nu) << MEAN_W;
            r_q   <= '0;
        end else if (r_dcnt != '0) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[MEAN_W-2:0], 1'b1};
            end else begin
                r_q <= {r_q[MEAN_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.out) r_mean <= (r_nu == '0) ? '0 : r_q;
    end

    assign o_sts.clr_last  = (r_clr_addr == MAW'(DEPTH - 1));
    assign o_sts.k_last    = (r_k == KW'(NUM_ITEMS - 1));
    assign o_sts.pipe_idle = !(r_v0 | r_v1 | r_v2);
    assign o_sts.q_zero    = (r_qu == '0) || (r_qv == '0);
    assign o_sts.mul_done  = (r_mcnt == '0);
    assign o_sts.srch_done = (r_lo >= r_hi);
    assign o_sts.div_done  = (r_dcnt == '0);

    assign o_valid      = r_vld;
    assign o_similarity = r_sim;
    assign o_mean_first = r_mean;

endmodule
